// ----- rtl/shps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shps_pkg: segment header page-size scanner package
// Status codes, field widths and limits shared by the scanner.
// ----------------------------------------------------------------------------
package shps_pkg;

    localparam int unsigned MAX_REFERRED_COUNT = 64;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned DIM_W       = 32;
    localparam int unsigned RES_W       = STATUS_W + 2 * DIM_W;
    localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam int unsigned CNT_W   = 32;
    localparam int unsigned TOTAL_W = 7;
    localparam int unsigned ACC_W   = 29;

    localparam logic [5:0] TYPE_PAGE_INFO = 6'd48;
    localparam logic [5:0] TYPE_EOF       = 6'd51;

    localparam logic [31:0] REF_SIZE2_LIMIT = 32'd256;
    localparam logic [31:0] REF_SIZE4_LIMIT = 32'd65536;
    localparam logic [31:0] LEN_UNKNOWN     = 32'hffff_ffff;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND  = 3'd0,
        ST_ENDED  = 3'd1,
        ST_COUNT  = 3'd2,
        ST_EOFSEG = 3'd3,
        ST_UNKLEN = 3'd4,
        ST_ZERO   = 3'd5
    } status_t;

    typedef struct packed {
        logic [DIM_W-1:0] page_height;
        logic [DIM_W-1:0] page_width;
        status_t          status;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/segment_header_page_size_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_header_page_size_scanner
// Walks segment headers of a byte stream and reports the first page size.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while s_axis_tready is high; each byte steps
// the header field machine, and a result is registered at the clock edge that
// takes the byte that completes it. A two-slot output buffer keeps input flowing
// while a result waits, so the input stalls only when both slots hold untaken
// results. One status transfer is sent per stream; bytes after it are dropped
// until a byte marked with first_byte restarts the parser.
// ----------------------------------------------------------------------------
module segment_header_page_size_scanner (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [shps_pkg::DATA_W-1:0]       s_axis_tdata,  // data_byte
    input  wire logic                              s_axis_tuser,  // first_byte
    input  wire logic                              s_axis_tlast,  // last_byte
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // status[2:0], page_width[34:3], page_height[66:35], zero fill above
    output logic [shps_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import shps_pkg::*;

    typedef enum logic [3:0] {
        PH_SEGNUM   = 4'd0,
        PH_FLAGS    = 4'd1,
        PH_COUNT    = 4'd2,
        PH_LONGCNT  = 4'd3,
        PH_RETAIN   = 4'd4,
        PH_REFS     = 4'd5,
        PH_PAGE     = 4'd6,
        PH_DLEN     = 4'd7,
        PH_DATA     = 4'd8,
        PH_WIDTH    = 4'd9,
        PH_HEIGHT   = 4'd10,
        PH_INFOSKIP = 4'd11,
        PH_STRIPE   = 4'd12
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                finished_reg, finished_next;
    logic [31:0]         segnum_reg, segnum_next;
    logic [7:0]          flags_reg, flags_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [31:0]         dlen_reg, dlen_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;

    result_t             out_reg, skid_reg, res;
    logic                out_valid_reg, skid_valid_reg;
    logic                res_valid;

    logic                accept, pop;
    phase_t              cur_phase;
    logic [CNT_W-1:0]    cur_cnt;
    logic                field_done;
    logic [CNT_W-1:0]    cnt_dec;
    logic [7:0]          b;
    logic [31:0]         shift_seg, shift_dlen, shift_acc32;
    logic [ACC_W-1:0]    long_cnt;
    logic [TOTAL_W-1:0]  refs_total;
    logic [CNT_W-1:0]    refs_n;
    logic [31:0]         height_shift;
    logic [14:0]         stripe_h;
    logic                st_hit;
    status_t             st_code;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_reg};

    assign b          = s_axis_tdata;
    assign cur_phase  = s_axis_tuser ? PH_SEGNUM : phase_reg;
    assign cur_cnt    = s_axis_tuser ? CNT_W'(4) : cnt_reg;
    assign cnt_dec    = (cur_cnt == '0) ? '0 : cur_cnt - CNT_W'(1);
    assign field_done = (cur_cnt <= CNT_W'(1));

    assign shift_seg    = {segnum_reg[23:0], b};
    assign shift_dlen   = {dlen_reg[23:0], b};
    assign shift_acc32  = {acc_reg[23:0], b};
    assign long_cnt     = shift_acc32[ACC_W-1:0];
    assign height_shift = {height_reg[23:0], b};
    assign stripe_h     = shift_acc32[14:0];

    // number of referred-to bytes for a given count and the current segment number
    assign refs_total = (cur_phase == PH_COUNT) ? TOTAL_W'(b[7:5]) : total_reg;
    always_comb
    begin
        refs_n = CNT_W'(refs_total);
        if (segnum_reg > REF_SIZE4_LIMIT)
        begin
            refs_n = CNT_W'(refs_total) << 2;
        end
        else if (segnum_reg > REF_SIZE2_LIMIT)
        begin
            refs_n = CNT_W'(refs_total) << 1;
        end
    end

    always_comb
    begin
        phase_next    = cur_phase;
        cnt_next      = cnt_dec;
        finished_next = s_axis_tuser ? 1'b0 : finished_reg;
        segnum_next   = segnum_reg;
        flags_next    = flags_reg;
        total_next    = total_reg;
        dlen_next     = dlen_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        acc_next      = acc_reg;
        st_hit        = 1'b0;
        st_code       = ST_FOUND;

        unique case (cur_phase)
            PH_SEGNUM:
            begin
                segnum_next = shift_seg;
                if (field_done)
                begin
                    phase_next = PH_FLAGS;
                    cnt_next   = CNT_W'(1);
                end
            end
            PH_FLAGS:
            begin
                flags_next = b;
                phase_next = PH_COUNT;
                cnt_next   = CNT_W'(1);
            end
            PH_COUNT:
            begin
                if (b[7:5] == 3'd7)
                begin
                    acc_next   = ACC_W'(b);
                    phase_next = PH_LONGCNT;
                    cnt_next   = CNT_W'(3);
                end
                else
                begin
                    total_next = refs_total;
                    if (refs_n == '0)
                    begin
                        phase_next = PH_PAGE;
                        cnt_next   = flags_reg[6] ? CNT_W'(4) : CNT_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_REFS;
                        cnt_next   = refs_n;
                    end
                end
            end
            PH_LONGCNT:
            begin
                acc_next = long_cnt;
                if (field_done)
                begin
                    if (long_cnt > ACC_W'(MAX_REFERRED_COUNT))
                    begin
                        st_hit  = 1'b1;
                        st_code = ST_COUNT;
                    end
                    else
                    begin
                        total_next = long_cnt[TOTAL_W-1:0];
                        phase_next = PH_RETAIN;
                        cnt_next   = CNT_W'(long_cnt[TOTAL_W-1:3]) + CNT_W'(1);
                    end
                end
            end
            PH_RETAIN:
            begin
                if (field_done)
                begin
                    if (refs_n == '0)
                    begin
                        phase_next = PH_PAGE;
                        cnt_next   = flags_reg[6] ? CNT_W'(4) : CNT_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_REFS;
                        cnt_next   = refs_n;
                    end
                end
            end
            PH_REFS:
            begin
                if (field_done)
                begin
                    phase_next = PH_PAGE;
                    cnt_next   = flags_reg[6] ? CNT_W'(4) : CNT_W'(1);
                end
            end
            PH_PAGE:
            begin
                if (field_done)
                begin
                    dlen_next  = '0;
                    phase_next = PH_DLEN;
                    cnt_next   = CNT_W'(4);
                end
            end
            PH_DLEN:
            begin
                dlen_next = shift_dlen;
                if (field_done)
                begin
                    priority if (flags_reg[5:0] == TYPE_PAGE_INFO)
                    begin
                        width_next = '0;
                        phase_next = PH_WIDTH;
                        cnt_next   = CNT_W'(4);
                    end
                    else if (flags_reg[5:0] == TYPE_EOF)
                    begin
                        st_hit  = 1'b1;
                        st_code = ST_EOFSEG;
                    end
                    else if (shift_dlen == LEN_UNKNOWN)
                    begin
                        st_hit  = 1'b1;
                        st_code = ST_UNKLEN;
                    end
                    else if (shift_dlen == '0)
                    begin
                        segnum_next = '0;
                        phase_next  = PH_SEGNUM;
                        cnt_next    = CNT_W'(4);
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        cnt_next   = shift_dlen;
                    end
                end
            end
            PH_DATA:
            begin
                if (field_done)
                begin
                    segnum_next = '0;
                    phase_next  = PH_SEGNUM;
                    cnt_next    = CNT_W'(4);
                end
            end
            PH_WIDTH:
            begin
                width_next = {width_reg[23:0], b};
                if (field_done)
                begin
                    height_next = '0;
                    phase_next  = PH_HEIGHT;
                    cnt_next    = CNT_W'(4);
                end
            end
            PH_HEIGHT:
            begin
                height_next = height_shift;
                if (field_done)
                begin
                    if (height_shift != LEN_UNKNOWN)
                    begin
                        st_hit  = 1'b1;
                        st_code = ST_FOUND;
                    end
                    else
                    begin
                        phase_next = PH_INFOSKIP;
                        cnt_next   = CNT_W'(9);
                    end
                end
            end
            PH_INFOSKIP:
            begin
                if (field_done)
                begin
                    acc_next   = '0;
                    phase_next = PH_STRIPE;
                    cnt_next   = CNT_W'(2);
                end
            end
            PH_STRIPE:
            begin
                acc_next = long_cnt;
                if (field_done)
                begin
                    st_hit = 1'b1;
                    if (stripe_h == '0)
                    begin
                        st_code = ST_ZERO;
                    end
                    else
                    begin
                        height_next = DIM_W'(stripe_h);
                        st_code     = ST_FOUND;
                    end
                end
            end
            default:
            begin
                segnum_next = '0;
                phase_next  = PH_SEGNUM;
                cnt_next    = CNT_W'(4);
            end
        endcase

        if (!st_hit && s_axis_tlast)
        begin
            st_hit  = 1'b1;
            st_code = ST_ENDED;
        end
        if (st_hit)
        begin
            finished_next = 1'b1;
        end
    end

    // drop bytes while finished, unless the byte restarts the stream
    assign res_valid = accept && (s_axis_tuser || !finished_reg) && st_hit;

    always_comb
    begin
        res.status      = st_code;
        res.page_width  = (st_code == ST_FOUND) ? width_reg : '0;
        res.page_height = (st_code == ST_FOUND) ? height_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEGNUM;
            cnt_reg      <= '0;
            finished_reg <= 1'b1;
        end
        else if (accept && (s_axis_tuser || !finished_reg))
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (s_axis_tuser || !finished_reg))
        begin
            segnum_reg <= segnum_next;
            flags_reg  <= flags_next;
            total_reg  <= total_next;
            dlen_reg   <= dlen_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            acc_reg    <= acc_next;
        end
    end

    // two-slot result buffer: head drives the port, skid holds the second
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= res_valid;
                end
                else
                begin
                    out_valid_reg  <= res_valid;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (res_valid)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (res_valid)
                begin
                    skid_reg <= res;
                end
            end
            else if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

endmodule
`default_nettype wire
